// File: rtl/atpg_pkg.sv
// ----------------------------------------------------------------------------
// Alarm tone pattern generator package
// Shared widths, timing constants, request codes, event codes and the
// quarter-wave sine table.
// ----------------------------------------------------------------------------
package atpg_pkg;

    localparam int SAMPLES_PER_MS = 16;

    localparam int OP_W      = 2;
    localparam int LEVEL_W   = 2;
    localparam int SAMPLE_W  = 14;
    localparam int EVENT_W   = 3;
    localparam int ROUNDS_W  = 16;
    localparam int POS_W     = 18;
    localparam int ELAPSED_W = 25;
    localparam int PHASE_W   = 8;
    localparam int TMO_W     = 20;
    localparam int TICKS_W   = TMO_W + 6;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    localparam logic [TMO_W-1:0]     TIMEOUT_RESET = TMO_W'(60000);
    localparam logic [POS_W-1:0]     POS_MAX       = '1;
    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX   = '1;
    localparam logic [ROUNDS_W-1:0]  ROUNDS_MAX    = '1;

    localparam logic [POS_W-1:0] ROUND_LEN_NOTICE  = POS_W'(200 * SAMPLES_PER_MS);
    localparam logic [POS_W-1:0] ROUND_LEN_WARNING = POS_W'(810 * SAMPLES_PER_MS);
    localparam logic [POS_W-1:0] ROUND_LEN_EMERG   = POS_W'(1000 * SAMPLES_PER_MS);
    localparam logic [POS_W-1:0] WARN_PERIOD       = POS_W'(270 * SAMPLES_PER_MS);
    localparam logic [POS_W-1:0] WARN_ON           = POS_W'(150 * SAMPLES_PER_MS);
    localparam logic [POS_W-1:0] EMERG_HALF        = POS_W'(250 * SAMPLES_PER_MS);
    localparam logic [31:0]      INTERVAL_WARNING  = 32'(10000 * SAMPLES_PER_MS);
    localparam logic [31:0]      INTERVAL_EMERG    = 32'(5000 * SAMPLES_PER_MS);

    localparam logic [PHASE_W-1:0] TAB_LEN    = PHASE_W'(160);
    localparam logic [PHASE_W-1:0] HALF_LEN   = PHASE_W'(80);
    localparam logic [PHASE_W-1:0] QUARTER_LEN = PHASE_W'(40);
    localparam logic [PHASE_W-1:0] STEP_1000  = PHASE_W'(10);
    localparam logic [PHASE_W-1:0] STEP_1200  = PHASE_W'(12);
    localparam logic [PHASE_W-1:0] STEP_700   = PHASE_W'(7);

    localparam logic [0:0] REG_TIMEOUT = 1'b0;

    typedef enum logic [OP_W-1:0] {
        OP_TICK    = 2'd0,
        OP_TRIGGER = 2'd1,
        OP_CLEAR   = 2'd2,
        OP_NOP     = 2'd3
    } op_t;

    typedef enum logic [LEVEL_W-1:0] {
        LVL_NONE      = 2'd0,
        LVL_NOTICE    = 2'd1,
        LVL_WARNING   = 2'd2,
        LVL_EMERGENCY = 2'd3
    } level_t;

    typedef enum logic [EVENT_W-1:0] {
        EV_NONE      = 3'd0,
        EV_TRIGGERED = 3'd1,
        EV_CLEARED   = 3'd2,
        EV_TIMEOUT   = 3'd3,
        EV_REJECTED  = 3'd4
    } event_t;

    localparam logic [SAMPLE_W-2:0] QUARTER_TAB [41] = '{
        13'd0,    13'd321,  13'd642,  13'd962,  13'd1281, 13'd1598, 13'd1912,
        13'd2223, 13'd2531, 13'd2835, 13'd3134, 13'd3429, 13'd3718, 13'd4002,
        13'd4280, 13'd4551, 13'd4814, 13'd5071, 13'd5320, 13'd5560, 13'd5792,
        13'd6015, 13'd6229, 13'd6433, 13'd6627, 13'd6811, 13'd6984, 13'd7147,
        13'd7298, 13'd7439, 13'd7568, 13'd7685, 13'd7790, 13'd7884, 13'd7965,
        13'd8034, 13'd8090, 13'd8134, 13'd8166, 13'd8185, 13'd8191
    };

    function automatic logic signed [SAMPLE_W-1:0] sine_at(logic [PHASE_W-1:0] ph);
        logic [PHASE_W-1:0]  idx;
        logic [5:0]          m;
        logic [SAMPLE_W-1:0] mag;
        idx = (ph >= HALF_LEN) ? ph - HALF_LEN : ph;
        m   = (idx <= QUARTER_LEN) ? idx[5:0] : 6'(HALF_LEN - idx);
        mag = {1'b0, QUARTER_TAB[m]};
        return (ph >= HALF_LEN) ? -$signed(mag) : $signed(mag);
    endfunction

endpackage

// File: rtl/atpg_if.sv
// ----------------------------------------------------------------------------
// Alarm tone pattern generator channels
// Request channel (operation, level) and result channel (sample, status).
// ----------------------------------------------------------------------------
interface atpg_req_if
    import atpg_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    operation;
    logic [LEVEL_W-1:0] alarm_level;

    modport source (output valid, output operation, output alarm_level, input ready);
    modport sink   (input valid, input operation, input alarm_level, output ready);
endinterface

interface atpg_res_if
    import atpg_pkg::*;
;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       alarm_active;
    logic [LEVEL_W-1:0]         current_level;
    logic [EVENT_W-1:0]         event_code;
    logic [ROUNDS_W-1:0]        round_count;

    modport source (output valid, output sample, output alarm_active,
                    output current_level, output event_code, output round_count,
                    input ready);
    modport sink   (input valid, input sample, input alarm_active,
                    input current_level, input event_code, input round_count,
                    output ready);
endinterface

// File: rtl/alarm_tone_pattern_generator.sv
// ----------------------------------------------------------------------------
// Alarm tone pattern generator
// Sounds notice, warning and emergency tone patterns one sample per request.
//
//   channel  | dir | handshake      | payload
//   ---------+-----+----------------+-------------------------------------------
//   req      | in  | valid / ready  | operation, alarm_level
//   res      | out | valid / ready  | sample, alarm_active, current_level,
//            |     |                | event_code, round_count
//   apb      | in  | psel / penable | timeout_ms at address 0
//
// One request per cycle; its result is in the result register on the next cycle.
// The sequencer update and the sine table lookup sit between the request port
// and the result register, so the rate is set by that single registered pass.
// A stalled result holds; a new request is taken when the result is consumed.
// Reset clears all alarm state and loads timeout_ms with 60000.
// ----------------------------------------------------------------------------
module alarm_tone_pattern_generator
    import atpg_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    atpg_req_if.sink           req,
    atpg_res_if.source         res
);

    logic [TMO_W-1:0]     timeout_reg;
    logic                 active_reg,   active_next;
    logic [LEVEL_W-1:0]   level_reg,    level_next;
    logic [POS_W-1:0]     pos_reg,      pos_next;
    logic [ELAPSED_W-1:0] elapsed_reg,  elapsed_next;
    logic [ROUNDS_W-1:0]  rounds_reg,   rounds_next;
    logic                 pending_reg,  pending_next;
    logic [PHASE_W-1:0]   ph_k_reg,     ph_k_next;
    logic [PHASE_W-1:0]   ph_hi_reg,    ph_hi_next;
    logic [PHASE_W-1:0]   ph_lo_reg,    ph_lo_next;

    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] sample_reg,  sample_next;
    logic                       out_active_reg;
    logic [LEVEL_W-1:0]         out_level_reg;
    logic [EVENT_W-1:0]         event_reg;
    event_t                     event_next;
    logic [ROUNDS_W-1:0]        out_rounds_reg;

    logic               accept;
    logic               cfg_write;
    logic [TICKS_W-1:0] tmo_ticks;
    logic [POS_W-1:0]   rl;
    logic [31:0]        iv;
    logic [POS_W-1:0]   pos_w;
    logic [PHASE_W-1:0] ph_k_w, ph_hi_w, ph_lo_w;

    function automatic logic [PHASE_W-1:0] adv(logic [PHASE_W-1:0] ph,
                                                logic [PHASE_W-1:0] step);
        logic [PHASE_W-1:0] sum;
        sum = ph + step;
        return (sum >= TAB_LEN) ? sum - TAB_LEN : sum;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] tone_at(
        logic [LEVEL_W-1:0] lvl, logic [POS_W-1:0] p,
        logic [PHASE_W-1:0] pk, logic [PHASE_W-1:0] phi, logic [PHASE_W-1:0] plo);
        logic [POS_W-1:0] seg;
        logic             high_half;
        seg       = (p >= (WARN_PERIOD << 1)) ? p - (WARN_PERIOD << 1) :
                    (p >= WARN_PERIOD) ? p - WARN_PERIOD : p;
        high_half = (p < EMERG_HALF) ||
                    ((p >= (EMERG_HALF << 1)) && (p < EMERG_HALF * POS_W'(3)));
        case (lvl)
            LVL_NOTICE:  return sine_at(pk);
            LVL_WARNING: return (seg >= WARN_ON) ? '0 : sine_at(pk);
            default:     return sine_at(high_half ? phi : plo);
        endcase
    endfunction

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = (paddr[2] == REG_TIMEOUT) ? PDATA_W'(timeout_reg) : '0;

    assign accept    = req.valid && req.ready;
    assign req.ready = !out_valid_reg || res.ready;
    assign tmo_ticks = TICKS_W'(timeout_reg) * TICKS_W'(SAMPLES_PER_MS);

    always_comb
    begin
        case (level_reg)
            LVL_NOTICE:    rl = ROUND_LEN_NOTICE;
            LVL_WARNING:   rl = ROUND_LEN_WARNING;
            LVL_EMERGENCY: rl = ROUND_LEN_EMERG;
            default:       rl = '0;
        endcase
        case (level_reg)
            LVL_WARNING:   iv = INTERVAL_WARNING;
            LVL_EMERGENCY: iv = INTERVAL_EMERG;
            default:       iv = '0;
        endcase
    end

    always_comb
    begin
        active_next  = active_reg;
        level_next   = level_reg;
        pos_next     = pos_reg;
        elapsed_next = elapsed_reg;
        rounds_next  = rounds_reg;
        pending_next = pending_reg;
        ph_k_next    = ph_k_reg;
        ph_hi_next   = ph_hi_reg;
        ph_lo_next   = ph_lo_reg;
        sample_next  = '0;
        event_next   = EV_NONE;
        pos_w        = pending_reg ? '0 : pos_reg;
        ph_k_w       = pending_reg ? '0 : ph_k_reg;
        ph_hi_w      = pending_reg ? '0 : ph_hi_reg;
        ph_lo_w      = pending_reg ? '0 : ph_lo_reg;

        case (req.operation)
            OP_TRIGGER:
            begin
                if (req.alarm_level == LVL_NONE)
                begin
                    event_next = EV_REJECTED;
                end
                else
                begin
                    event_next = EV_TRIGGERED;
                    if (!active_reg || (req.alarm_level > level_reg))
                    begin
                        active_next  = 1'b1;
                        level_next   = req.alarm_level;
                        elapsed_next = '0;
                        rounds_next  = '0;
                        pending_next = 1'b1;
                        pos_next     = '0;
                    end
                    else if (!pending_reg && (pos_reg >= rl))
                    begin
                        pending_next = 1'b1;
                    end
                end
            end
            OP_CLEAR:
            begin
                if (active_reg)
                begin
                    active_next  = 1'b0;
                    level_next   = '0;
                    pending_next = 1'b0;
                    pos_next     = '0;
                    ph_k_next    = '0;
                    ph_hi_next   = '0;
                    ph_lo_next   = '0;
                    event_next   = EV_CLEARED;
                end
            end
            OP_TICK:
            begin
                if (active_reg)
                begin
                    if (pending_reg && (TICKS_W'(elapsed_reg) >= tmo_ticks))
                    begin
                        active_next  = 1'b0;
                        level_next   = '0;
                        pending_next = 1'b0;
                        pos_next     = '0;
                        ph_k_next    = '0;
                        ph_hi_next   = '0;
                        ph_lo_next   = '0;
                        event_next   = EV_TIMEOUT;
                    end
                    else
                    begin
                        ph_k_next  = ph_k_w;
                        ph_hi_next = ph_hi_w;
                        ph_lo_next = ph_lo_w;
                        if (pos_w < rl)
                        begin
                            sample_next = tone_at(level_reg, pos_w, ph_k_w, ph_hi_w, ph_lo_w);
                            ph_k_next   = adv(ph_k_w, STEP_1000);
                            ph_hi_next  = adv(ph_hi_w, STEP_1200);
                            ph_lo_next  = adv(ph_lo_w, STEP_700);
                        end
                        pos_next     = (pos_w != POS_MAX) ? pos_w + 1'b1 : pos_w;
                        elapsed_next = (elapsed_reg != ELAPSED_MAX) ?
                                       elapsed_reg + 1'b1 : elapsed_reg;
                        pending_next = 1'b0;
                        if (pos_next >= rl)
                        begin
                            if ((pos_next == rl) && (rounds_reg != ROUNDS_MAX))
                            begin
                                rounds_next = rounds_reg + 1'b1;
                            end
                            pending_next = ((iv != '0) && (32'(pos_next) >= iv)) ||
                                           (pos_next == POS_MAX) ||
                                           (TICKS_W'(elapsed_next) >= tmo_ticks);
                        end
                    end
                end
            end
            default:
            begin
                event_next = EV_NONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg   <= TIMEOUT_RESET;
            active_reg    <= 1'b0;
            level_reg     <= '0;
            pos_reg       <= '0;
            elapsed_reg   <= '0;
            rounds_reg    <= '0;
            pending_reg   <= 1'b0;
            ph_k_reg      <= '0;
            ph_hi_reg     <= '0;
            ph_lo_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write && (paddr[2] == REG_TIMEOUT))
            begin
                timeout_reg <= pwdata[TMO_W-1:0];
            end
            if (accept)
            begin
                active_reg    <= active_next;
                level_reg     <= level_next;
                pos_reg       <= pos_next;
                elapsed_reg   <= elapsed_next;
                rounds_reg    <= rounds_next;
                pending_reg   <= pending_next;
                ph_k_reg      <= ph_k_next;
                ph_hi_reg     <= ph_hi_next;
                ph_lo_reg     <= ph_lo_next;
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sample_reg     <= sample_next;
            out_active_reg <= active_next;
            out_level_reg  <= active_next ? level_next : '0;
            event_reg      <= event_next;
            out_rounds_reg <= rounds_next;
        end
    end

    assign res.valid         = out_valid_reg;
    assign res.sample        = sample_reg;
    assign res.alarm_active  = out_active_reg;
    assign res.current_level = out_level_reg;
    assign res.event_code    = event_reg;
    assign res.round_count   = out_rounds_reg;

endmodule

// File: rtl/atpg_checker.sv
// ----------------------------------------------------------------------------
// Alarm tone pattern generator checker
// Port-level properties of the request and result channels, bound to the top.
// ----------------------------------------------------------------------------
module atpg_checker
    import atpg_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                req_valid,
    input logic                req_ready,
    input logic                res_valid,
    input logic                res_ready,
    input logic                res_alarm_active,
    input logic [LEVEL_W-1:0]  res_current_level,
    input logic [EVENT_W-1:0]  res_event_code,
    input logic [ROUNDS_W-1:0] res_round_count
);

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_round_count)
                                    && $stable(res_event_code))
        else $error("result dropped or changed while stalled");

    a_req_to_res: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> res_valid)
        else $error("accepted request produced no result");

    a_idle_level: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_alarm_active |-> res_current_level == LVL_NONE)
        else $error("level reported while alarm inactive");

    a_stop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_event_code == EV_CLEARED || res_event_code == EV_TIMEOUT)
        |-> !res_alarm_active)
        else $error("alarm still active after clear or timeout");

    a_trig_active: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_event_code == EV_TRIGGERED
        |-> res_alarm_active && res_current_level != LVL_NONE)
        else $error("trigger left alarm inactive");

endmodule

bind alarm_tone_pattern_generator atpg_checker u_atpg_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .req_valid         (req.valid),
    .req_ready         (req.ready),
    .res_valid         (res.valid),
    .res_ready         (res.ready),
    .res_alarm_active  (res.alarm_active),
    .res_current_level (res.current_level),
    .res_event_code    (res.event_code),
    .res_round_count   (res.round_count)
);

// File: sim/atpg_score_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Alarm tone scoreboard
// Follows the alarm sequencer (levels, rounds, gaps, timeout) and the three
// tone phase accumulators for every accepted request. It queues the status
// word that each request must produce and checks every result, in order,
// against the oldest queued one.
// ----------------------------------------------------------------------------
package atpg_score_pkg;
    import atpg_pkg::*;

    localparam real PI = 3.14159265358979323846;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       alarm_active;
        logic [LEVEL_W-1:0]         level;
        logic [EVENT_W-1:0]         code;
        logic [ROUNDS_W-1:0]        rounds;
    } status_t;

    class tone_scoreboard;
        logic [TMO_W-1:0]           timeout_ms;
        logic                       active;
        level_t                     level;
        logic [POS_W-1:0]           pos;
        logic [ELAPSED_W-1:0]       elapsed;
        logic [ROUNDS_W-1:0]        rounds;
        logic                       restart;
        logic [PHASE_W-1:0]         ph_1000;
        logic [PHASE_W-1:0]         ph_1200;
        logic [PHASE_W-1:0]         ph_700;
        logic signed [SAMPLE_W-1:0] wave [160];
        status_t                    awaited [$];
        int                         errors;
        int                         checked;
        int                         tally [5];
        int                         peak_rounds;

        function new();
            int quarter [41];
            int m;
            for (int k = 0; k <= 40; k++)
                quarter[k] = $rtoi(8191.75 * $sin(PI * k / 80.0));
            for (int k = 0; k < 160; k++)
            begin
                m = (k % 80 <= 40) ? k % 80 : 80 - k % 80;
                wave[k] = (k >= 80) ? -quarter[m] : quarter[m];
            end
            timeout_ms  = TMO_W'(60000);
            elapsed     = '0;
            rounds      = '0;
            errors      = 0;
            checked     = 0;
            peak_rounds = 0;
            foreach (tally[i])
                tally[i] = 0;
            silence();
        endfunction

        function void silence();
            active  = 1'b0;
            level   = LVL_NONE;
            restart = 1'b0;
            pos     = '0;
            ph_1000 = '0;
            ph_1200 = '0;
            ph_700  = '0;
        endfunction

        function int round_ticks(level_t l);
            case (l)
                LVL_NOTICE:    return 200 * SAMPLES_PER_MS;
                LVL_WARNING:   return 810 * SAMPLES_PER_MS;
                LVL_EMERGENCY: return 1000 * SAMPLES_PER_MS;
                default:       return 0;
            endcase
        endfunction

        function int repeat_ticks(level_t l);
            case (l)
                LVL_WARNING:   return 10000 * SAMPLES_PER_MS;
                LVL_EMERGENCY: return 5000 * SAMPLES_PER_MS;
                default:       return 0;
            endcase
        endfunction

        function logic [PHASE_W-1:0] advance_phase(logic [PHASE_W-1:0] ph, int inc);
            int p;
            p = ph % 160 + inc;
            return PHASE_W'((p >= 160) ? p - 160 : p);
        endfunction

        function logic signed [SAMPLE_W-1:0] tone();
            int p;
            p = pos;
            if (level == LVL_WARNING && p % (270 * SAMPLES_PER_MS) >= 150 * SAMPLES_PER_MS)
                return '0;
            if (level != LVL_EMERGENCY)
                return wave[ph_1000];
            if (p % (500 * SAMPLES_PER_MS) < 250 * SAMPLES_PER_MS)
                return wave[ph_1200];
            return wave[ph_700];
        endfunction

        function void note_request(op_t op, level_t lvl);
            longint  tmo;
            status_t st;
            int      len;
            int      iv;
            logic    timed_out;
            tmo       = longint'(timeout_ms) * SAMPLES_PER_MS;
            st.sample = '0;
            st.code   = EV_NONE;
            timed_out = 1'b0;
            case (op)
                OP_TRIGGER:
                begin
                    if (lvl == LVL_NONE)
                        st.code = EV_REJECTED;
                    else
                    begin
                        st.code = EV_TRIGGERED;
                        if (!active || lvl > level)
                        begin
                            active  = 1'b1;
                            level   = lvl;
                            elapsed = '0;
                            rounds  = '0;
                            restart = 1'b1;
                            pos     = '0;
                        end
                        else if (!restart && pos >= round_ticks(level))
                            restart = 1'b1;
                    end
                end
                OP_CLEAR:
                begin
                    if (active)
                    begin
                        silence();
                        st.code = EV_CLEARED;
                    end
                end
                OP_TICK:
                begin
                    if (active)
                    begin
                        if (restart)
                        begin
                            if (elapsed >= tmo)
                            begin
                                silence();
                                st.code   = EV_TIMEOUT;
                                timed_out = 1'b1;
                            end
                            else
                            begin
                                restart = 1'b0;
                                pos     = '0;
                                ph_1000 = '0;
                                ph_1200 = '0;
                                ph_700  = '0;
                            end
                        end
                        if (!timed_out)
                        begin
                            len = round_ticks(level);
                            if (pos < len)
                            begin
                                st.sample = tone();
                                ph_1000   = advance_phase(ph_1000, 10);
                                ph_1200   = advance_phase(ph_1200, 12);
                                ph_700    = advance_phase(ph_700, 7);
                            end
                            if (!(&pos))
                                pos = pos + 1'b1;
                            if (!(&elapsed))
                                elapsed = elapsed + 1'b1;
                            if (pos >= len)
                            begin
                                iv = repeat_ticks(level);
                                if (pos == len && !(&rounds))
                                    rounds = rounds + 1'b1;
                                if ((iv != 0 && pos >= iv) || (&pos) || elapsed >= tmo)
                                    restart = 1'b1;
                            end
                        end
                    end
                end
                default: ;
            endcase
            st.alarm_active = active;
            st.level        = active ? level : LVL_NONE;
            st.rounds       = rounds;
            tally[st.code]++;
            if (rounds > peak_rounds)
                peak_rounds = rounds;
            awaited.push_back(st);
        endfunction

        function void compare(string field, logic signed [31:0] want, logic signed [31:0] got);
            if (got !== want)
            begin
                errors++;
                if (errors <= 100)
                    $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
            end
        endfunction

        function void check_result(status_t got);
            status_t want;
            if (awaited.size() == 0)
            begin
                errors++;
                $display("%0t: result with no request outstanding, sample %0d event %0d",
                         $time, got.sample, got.code);
                return;
            end
            want = awaited.pop_front();
            checked++;
            compare("sample", want.sample, got.sample);
            compare("alarm_active", want.alarm_active, got.alarm_active);
            compare("current_level", want.level, got.level);
            compare("event_code", want.code, got.code);
            compare("round_count", want.rounds, got.rounds);
        endfunction
    endclass

endpackage

// File: sim/alarm_tone_pattern_generator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Alarm tone pattern generator testbench
// Sends triggers, clears, ignored codes and sample ticks through the request
// channel with random gaps and result back-pressure, programs the timeout over
// APB between phases, and checks every result word against the scoreboard.
// Short tick runs under small and large timeouts cover restarts and
// timeouts; a stretch with no idling on either side closes the run.
// ----------------------------------------------------------------------------
module alarm_tone_pattern_generator_tb;
    import atpg_pkg::*;
    import atpg_score_pkg::*;

    localparam logic [PADDR_W-1:0] TIMEOUT_ADDR = PADDR_W'(4 * REG_TIMEOUT);

    logic               clk = 1'b0;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    bit                 steady;
    int                 settings_used;

    tone_scoreboard board;

    atpg_req_if req ();
    atpg_res_if res ();

    alarm_tone_pattern_generator dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .req     (req),
        .res     (res)
    );

    always #2 clk = ~clk;

    initial
    begin
        #20_000_000;
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        res.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            res.ready = steady || ($urandom_range(99) >= 30);
        end
    end

    always @(posedge clk)
        if (rst_n && res.valid && res.ready)
            board.check_result('{res.sample, res.alarm_active, res.current_level,
                                 res.event_code, res.round_count});

    task automatic send_req(input op_t op, input level_t lvl);
        while (!steady && $urandom_range(99) < 30)
        begin
            req.valid       = 1'b0;
            req.operation   = OP_W'($urandom_range(3));
            req.alarm_level = LEVEL_W'($urandom_range(3));
            @(negedge clk);
        end
        req.valid       = 1'b1;
        req.operation   = op;
        req.alarm_level = lvl;
        do
            @(posedge clk);
        while (!req.ready);
        board.note_request(op, lvl);
        @(negedge clk);
    endtask

    task automatic tick_run(input int n);
        repeat (n)
            send_req(OP_TICK, level_t'($urandom_range(3)));
    endtask

    task automatic program_timeout(input logic [TMO_W-1:0] ms);
        logic [PDATA_W-1:0] word;
        req.valid = 1'b0;
        while (board.awaited.size() != 0)
            @(negedge clk);
        repeat (2)
            @(negedge clk);
        word    = PDATA_W'(ms) | (PDATA_W'($urandom()) << TMO_W);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = TIMEOUT_ADDR;
        pwdata  = word;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        board.timeout_ms = ms;
        settings_used++;
        pwrite  = 1'b0;
        penable = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        board.compare("timeout_ms readback", PDATA_W'(ms), prdata);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic scene(input int longest);
        int r;
        send_req(OP_TRIGGER, level_t'($urandom_range(3, 1)));
        repeat ($urandom_range(4, 1))
        begin
            tick_run($urandom_range(longest));
            r = $urandom_range(99);
            if (r < 40)
                send_req(OP_TRIGGER, level_t'($urandom_range(3)));
            else if (r < 55)
                send_req(op_t'($urandom_range(3)), level_t'($urandom_range(3)));
            else if (r < 65)
                send_req(OP_CLEAR, level_t'($urandom_range(3)));
        end
    endtask

    initial
    begin
        board           = new();
        rst_n           = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        req.valid       = 1'b0;
        req.operation   = OP_TICK;
        req.alarm_level = LVL_NONE;
        steady          = 1'b0;
        settings_used   = 0;
        repeat (11)
            @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_req(OP_TICK, LVL_EMERGENCY);
        send_req(OP_CLEAR, LVL_NONE);
        send_req(OP_NOP, LVL_EMERGENCY);
        send_req(OP_TRIGGER, LVL_NONE);
        send_req(OP_TRIGGER, LVL_NOTICE);
        tick_run(3);
        send_req(OP_TRIGGER, LVL_NOTICE);
        send_req(OP_TRIGGER, LVL_WARNING);
        tick_run(2);
        send_req(OP_TRIGGER, LVL_NOTICE);
        send_req(OP_TICK, LVL_WARNING);
        send_req(OP_TRIGGER, LVL_EMERGENCY);
        tick_run(3);
        send_req(OP_NOP, LVL_NONE);
        send_req(OP_TICK, LVL_NOTICE);
        send_req(OP_CLEAR, LVL_EMERGENCY);
        send_req(OP_TICK, LVL_NONE);
        send_req(OP_CLEAR, LVL_NOTICE);

        program_timeout(TMO_W'(0));
        send_req(OP_TRIGGER, LVL_WARNING);
        send_req(OP_TICK, LVL_NONE);
        send_req(OP_TICK, LVL_NONE);

        program_timeout(TMO_W'(1));
        send_req(OP_TRIGGER, LVL_NOTICE);
        tick_run(20);
        send_req(OP_TRIGGER, LVL_WARNING);
        tick_run(20);
        send_req(OP_TRIGGER, LVL_EMERGENCY);
        tick_run(20);
        send_req(OP_CLEAR, LVL_NONE);

        program_timeout(TMO_W'(1500));
        send_req(OP_TRIGGER, LVL_NOTICE);
        tick_run(30);
        send_req(OP_TRIGGER, LVL_NOTICE);
        tick_run(10);
        send_req(OP_TRIGGER, LVL_EMERGENCY);
        tick_run(30);

        program_timeout(TMO_W'(0));
        repeat (14)
            scene(16);
        program_timeout(TMO_W'($urandom_range(3, 1)));
        repeat (14)
            scene(16);
        program_timeout(TMO_W'($urandom_range((1 << TMO_W) - 1, 1)));
        repeat (14)
            scene(16);
        program_timeout('1);
        repeat (14)
            scene(16);

        steady = 1'b1;
        program_timeout(TMO_W'($urandom_range(3, 1)));
        repeat (8)
            scene(16);
        send_req(OP_CLEAR, LVL_NONE);
        steady = 1'b0;

        req.valid = 1'b0;
        while (board.awaited.size() != 0)
            @(negedge clk);
        repeat (4)
            @(negedge clk);

        $display("Checked %0d results under %0d timeout settings, peak round count %0d",
                 board.checked, settings_used, board.peak_rounds);
        $display("Events: %0d triggered, %0d cleared, %0d timed out, %0d rejected",
                 board.tally[EV_TRIGGERED], board.tally[EV_CLEARED],
                 board.tally[EV_TIMEOUT], board.tally[EV_REJECTED]);
        if (board.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
